[rtl/sgbk_pkg.sv]
// sgbk_pkg: shared types and constants of the stable group-by-key block
// holds transaction structs, sequencer states and control/status bundles
// no dependencies
package sgbk_pkg;

  // field widths of one transaction
  localparam int unsigned HandleFieldW = 16;
  localparam int unsigned KeyFieldW    = 16;

  // default module parameters
  localparam int unsigned MaxItemsDef   = 64;
  localparam int unsigned KeyBitsDef    = 16;
  localparam int unsigned HandleBitsDef = 16;

  typedef struct packed {
    logic [HandleFieldW-1:0] item_handle;
    logic [KeyFieldW-1:0]    group_key;
    logic                    last_item;
  } item_t;

  typedef struct packed {
    logic [HandleFieldW-1:0] handle_out;
    logic [KeyFieldW-1:0]    key_out;
    logic                    last_out;
    logic                    overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMPARE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FLUSH
  } state_e;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic accept;   // start taken this cycle
    logic in_last;  // last mark of the incoming transaction
    logic last_q;   // last mark of the captured transaction
    logic fits;     // store has room for one more item
    logic g_end;    // group counter reached group count
    logic i_end;    // item counter reached item count
    logic eq;       // shared comparator result
  } sts_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic ld_item;
    logic clr_g;
    logic inc_g;
    logic clr_i;
    logic inc_i;
    logic tbl_we;
    logic item_we;
    logic set_drop;
    logic sel_emit;
    logic emit_match;
    logic flush;
    logic clr_run;
  } ctrl_t;

endpackage

[rtl/sgbk_ram.sv]
// sgbk_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
module sgbk_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sgbk_fsm.sv]
// sgbk_fsm: sequencer of the stable group-by-key block
// drives the shared comparator, counters and stores; uses sgbk_pkg
module sgbk_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sgbk_pkg::sts_t sts_i,
  output sgbk_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);
  import sgbk_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.accept) begin
          if (sts_i.fits) begin
            state_d = ST_LOOKUP;
          end else if (sts_i.in_last) begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_LOOKUP: begin
        if (sts_i.g_end) begin
          state_d = sts_i.last_q ? ST_SCAN_RD : ST_IDLE;
        end else begin
          state_d = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (sts_i.eq) begin
          state_d = sts_i.last_q ? ST_SCAN_RD : ST_IDLE;
        end else begin
          state_d = ST_LOOKUP;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.g_end) begin
          state_d = ST_FLUSH;
        end else if (!sts_i.i_end) begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: state_d = ST_SCAN_RD;
      ST_FLUSH:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.accept) begin
          ctrl_o.ld_item = 1'b1;
          ctrl_o.clr_g   = 1'b1;
          ctrl_o.clr_i   = 1'b1;
          if (!sts_i.fits) begin
            ctrl_o.set_drop = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        if (sts_i.g_end) begin
          ctrl_o.tbl_we  = 1'b1;
          ctrl_o.item_we = 1'b1;
          ctrl_o.clr_g   = 1'b1;
        end
      end
      ST_COMPARE: begin
        if (sts_i.eq) begin
          ctrl_o.item_we = 1'b1;
          ctrl_o.clr_g   = 1'b1;
        end else begin
          ctrl_o.inc_g = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        ctrl_o.sel_emit = 1'b1;
        if (!sts_i.g_end && sts_i.i_end) begin
          ctrl_o.inc_g = 1'b1;
          ctrl_o.clr_i = 1'b1;
        end
      end
      ST_SCAN_CMP: begin
        ctrl_o.sel_emit   = 1'b1;
        ctrl_o.emit_match = sts_i.eq;
        ctrl_o.inc_i      = 1'b1;
      end
      ST_FLUSH: begin
        ctrl_o.flush   = 1'b1;
        ctrl_o.clr_run = 1'b1;
      end
      default: ctrl_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/stable_group_by_key.sv]
// stable_group_by_key: regroups a list of items by key in first-appearance order
// emit: the scan walks all items for each group, one compare per item read
// throughput set by the single key/group comparator and the one read port of each store
// results are strobed for one cycle and cannot be stalled; async active-low reset
// clears the sequencer, counters and overflow flag; stores are not cleared
module stable_group_by_key #(
  parameter int unsigned MAX_ITEMS   = sgbk_pkg::MaxItemsDef,
  parameter int unsigned KEY_BITS    = sgbk_pkg::KeyBitsDef,
  parameter int unsigned HANDLE_BITS = sgbk_pkg::HandleBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sgbk_pkg::item_t   item_i,
  output logic              out_valid_o,
  output sgbk_pkg::result_t result_o
);
  import sgbk_pkg::*;

  // stored widths: only the low bits of each field are kept
  localparam int unsigned KeyW   = (KEY_BITS < KeyFieldW) ? KEY_BITS : KeyFieldW;
  localparam int unsigned HdlW   = (HANDLE_BITS < HandleFieldW) ? HANDLE_BITS : HandleFieldW;
  localparam int unsigned IdxW   = $clog2(MAX_ITEMS);
  localparam int unsigned CntW   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ItemW  = HdlW + KeyW + IdxW;
  localparam int unsigned CmpW   = (KeyW > IdxW) ? KeyW : IdxW;

  sts_t  sts;
  ctrl_t ctrl;

  // captured transaction
  logic [HdlW-1:0] handle_q;
  logic [KeyW-1:0] key_q;
  logic            last_q;

  // run state
  logic [CntW-1:0] item_cnt_q, item_cnt_d;
  logic [CntW-1:0] grp_cnt_q, grp_cnt_d;
  logic            drop_q, drop_d;

  // loop counters: g walks groups, i walks items
  logic [CntW-1:0] g_q, g_d;
  logic [CntW-1:0] i_q, i_d;

  // store ports
  logic [ItemW-1:0] item_wdata, item_rdata;
  logic [KeyW-1:0]  tbl_rdata;
  logic [HdlW-1:0]  rd_handle;
  logic [KeyW-1:0]  rd_key;
  logic [IdxW-1:0]  rd_grp;

  // shared comparator
  logic [CmpW-1:0] cmp_a, cmp_b;

  // pending result, held back one match so the final one can carry last_out
  logic            pend_vld_q, pend_vld_d;
  logic [HdlW-1:0] pend_handle_q;
  logic [KeyW-1:0] pend_key_q;

  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;

  sgbk_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // item store: handle, key and group index of each loaded item
  assign item_wdata = {handle_q, key_q, g_q[IdxW-1:0]};

  sgbk_ram #(
    .WIDTH (ItemW),
    .DEPTH (MAX_ITEMS)
  ) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.item_we),
    .waddr_i (item_cnt_q[IdxW-1:0]),
    .wdata_i (item_wdata),
    .raddr_i (i_q[IdxW-1:0]),
    .rdata_o (item_rdata)
  );

  // group key table in first-appearance order
  sgbk_ram #(
    .WIDTH (KeyW),
    .DEPTH (MAX_ITEMS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.tbl_we),
    .waddr_i (grp_cnt_q[IdxW-1:0]),
    .wdata_i (key_q),
    .raddr_i (g_q[IdxW-1:0]),
    .rdata_o (tbl_rdata)
  );

  assign rd_handle = item_rdata[ItemW-1 -: HdlW];
  assign rd_key    = item_rdata[IdxW +: KeyW];
  assign rd_grp    = item_rdata[IdxW-1:0];

  // one equality unit: table key vs. new key while loading,
  // item group vs. current group while emitting
  always_comb begin
    if (ctrl.sel_emit) begin
      cmp_a = CmpW'(rd_grp);
      cmp_b = CmpW'(g_q[IdxW-1:0]);
    end else begin
      cmp_a = CmpW'(tbl_rdata);
      cmp_b = CmpW'(key_q);
    end
  end

  // status toward the sequencer
  assign sts.accept  = start && !busy;
  assign sts.in_last = item_i.last_item;
  assign sts.last_q  = last_q;
  assign sts.fits    = (item_cnt_q < CntW'(MAX_ITEMS));
  assign sts.g_end   = (g_q == grp_cnt_q);
  assign sts.i_end   = (i_q == item_cnt_q);
  assign sts.eq      = (cmp_a == cmp_b);

  // captured transaction, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_item) begin
      handle_q <= item_i.item_handle[HdlW-1:0];
      key_q    <= item_i.group_key[KeyW-1:0];
      last_q   <= item_i.last_item;
    end
  end

  // counters and run flags
  always_comb begin
    item_cnt_d = item_cnt_q;
    grp_cnt_d  = grp_cnt_q;
    drop_d     = drop_q;
    g_d        = g_q;
    i_d        = i_q;
    if (ctrl.item_we)  item_cnt_d = item_cnt_q + 1'b1;
    if (ctrl.tbl_we)   grp_cnt_d  = grp_cnt_q + 1'b1;
    if (ctrl.set_drop) drop_d     = 1'b1;
    if (ctrl.clr_g) begin
      g_d = '0;
    end else if (ctrl.inc_g) begin
      g_d = g_q + 1'b1;
    end
    if (ctrl.clr_i) begin
      i_d = '0;
    end else if (ctrl.inc_i) begin
      i_d = i_q + 1'b1;
    end
    // end of run: ready for a new list
    if (ctrl.clr_run) begin
      item_cnt_d = '0;
      grp_cnt_d  = '0;
      drop_d     = 1'b0;
    end
  end

  // result staging: a new match pushes out the previous one,
  // the flush at the end of the scan sends the held one as last
  always_comb begin
    pend_vld_d  = pend_vld_q;
    out_valid_d = 1'b0;
    result_d    = result_q;
    if (ctrl.emit_match || ctrl.flush) begin
      out_valid_d       = pend_vld_q;
      result_d.handle_out = HandleFieldW'(pend_handle_q);
      result_d.key_out    = KeyFieldW'(pend_key_q);
      result_d.last_out   = ctrl.flush;
      result_d.overflow   = drop_q;
    end
    if (ctrl.emit_match) begin
      pend_vld_d = 1'b1;
    end else if (ctrl.flush) begin
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_match) begin
      pend_handle_q <= rd_handle;
      pend_key_q    <= rd_key;
    end
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cnt_q  <= '0;
      grp_cnt_q   <= '0;
      drop_q      <= 1'b0;
      g_q         <= '0;
      i_q         <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      item_cnt_q  <= item_cnt_d;
      grp_cnt_q   <= grp_cnt_d;
      drop_q      <= drop_d;
      g_q         <= g_d;
      i_q         <= i_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // store never overfills
  a_item_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_cnt_q <= CntW'(MAX_ITEMS))
    else $error("item count beyond store depth");

  // every group has at least one item
  a_grp_le_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q <= item_cnt_q)
    else $error("group count exceeds item count");

  // the final transaction of a run leaves the block idle with a cleared run
  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_o.last_out |-> !busy && item_cnt_q == '0)
    else $error("run not closed after final result");

  // the block only becomes busy from a start
  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

endmodule

[test/tb_top.sv]
// tb_top: self-checking testbench of stable_group_by_key, with directed lists and then random ones
// predicts the grouped result stream of each list and checks every strobed result field by field
// depends on sgbk_pkg (item_t, result_t, MaxItemsDef) and the stable_group_by_key rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sgbk_pkg::*;

  localparam int unsigned StoreDepth  = MaxItemsDef;
  // watchdog limit on the whole simulation, with a wide margin
  localparam int unsigned CycleLimit  = 1_000_000;
  // extra cycles after the last expected result, to catch stray strobes
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned RandomItems = 230;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  item_t   item_d = '0;
  logic    busy;
  logic    out_valid_o;
  result_t result_o;

  // sender idling: when set, transactions go back to back
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_seen = 0;

  // predictor state: one open list, stored as the block stores it
  logic [15:0] held_handle [StoreDepth];
  logic [15:0] held_key    [StoreDepth];
  logic [5:0]  held_group  [StoreDepth];
  logic [15:0] first_keys  [StoreDepth];
  int unsigned held_count  = 0;
  int unsigned group_total = 0;
  bit          run_dropped = 1'b0;

  // grouped results still owed by the block, oldest first
  result_t grouped_q [$];
  result_t want;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  stable_group_by_key dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_d),
    .out_valid_o (out_valid_o),
    .result_o    (result_o)
  );

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] ERROR %s", $realtime, what);
  endtask

  // stores one accepted item and, on the last mark, queues the whole regrouped list
  function automatic void predict_grouping(item_t it);
    int unsigned hit;
    int unsigned emitted;
    result_t     r;
    if (held_count < StoreDepth) begin
      hit = group_total;
      // first-appearance key table lookup
      for (int unsigned g = 0; g < group_total && hit == group_total; g++) begin
        if (first_keys[g] == it.group_key) begin
          hit = g;
        end
      end
      if (hit == group_total) begin
        first_keys[group_total] = it.group_key;
        group_total++;
      end
      held_handle[held_count] = it.item_handle;
      held_key[held_count]    = it.group_key;
      held_group[held_count]  = hit[5:0];
      held_count++;
    end else begin
      // store full: item is lost, but the run still goes out
      run_dropped = 1'b1;
    end
    if (it.last_item) begin
      emitted = 0;
      // groups in order of first appearance, items in arrival order within a group
      for (int unsigned g = 0; g < group_total; g++) begin
        for (int unsigned i = 0; i < held_count; i++) begin
          if (held_group[i] == g[5:0]) begin
            r.handle_out = held_handle[i];
            r.key_out    = held_key[i];
            r.last_out   = (emitted == held_count - 1);
            r.overflow   = run_dropped;
            grouped_q.push_back(r);
            emitted++;
          end
        end
      end
      held_count  = 0;
      group_total = 0;
      run_dropped = 1'b0;
    end
  endfunction

  // one input transaction: hold it until accepted, predict, then idle for a drawn gap
  task automatic send_item(item_t it);
    int unsigned gap;
    start  <= 1'b1;
    item_d <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_grouping(it);
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // a whole list with random handles; keys come from a small pool with now and then a random one, or are all distinct
  task automatic send_list(int unsigned len, int unsigned pool_size, bit distinct);
    logic [15:0] pool [8];
    logic [15:0] base;
    item_t       it;
    base = 16'($urandom);
    foreach (pool[p]) pool[p] = 16'($urandom);
    for (int unsigned n = 0; n < len; n++) begin
      it.item_handle = 16'($urandom);
      if (distinct) begin
        it.group_key = base ^ 16'(n);
      end else if ($urandom_range(0, 7) == 0) begin
        it.group_key = 16'($urandom);
      end else begin
        it.group_key = pool[$urandom_range(0, pool_size - 1)];
      end
      it.last_item = (n == len - 1);
      send_item(it);
    end
  endtask

  // lists of one item, at both ends of the field ranges
  task automatic test_single_item();
    send_item(item_t'{16'h0000, 16'h0000, 1'b1});
    send_item(item_t'{16'hFFFF, 16'hFFFF, 1'b1});
  endtask

  // all-zero and all-ones fields mixed, sent back to back
  task automatic test_field_extremes();
    no_idle = 1'b1;
    send_item(item_t'{16'hFFFF, 16'hFFFF, 1'b0});
    send_item(item_t'{16'h0000, 16'h0000, 1'b0});
    send_item(item_t'{16'hFFFF, 16'h0000, 1'b0});
    send_item(item_t'{16'h0000, 16'hFFFF, 1'b1});
    no_idle = 1'b0;
  endtask

  // keys that come back after other keys: groups must pull their later items forward
  task automatic test_interleaved_keys();
    logic [15:0] keys [7];
    keys = '{16'h5555, 16'hAAAA, 16'h5555, 16'h0001, 16'hAAAA, 16'h5555, 16'h0001};
    for (int unsigned n = 0; n < 7; n++) begin
      send_item(item_t'{16'(n + 1), keys[n], n == 6});
    end
  endtask

  // one key for the whole list: arrival order must stay untouched
  task automatic test_one_group();
    for (int unsigned n = 0; n < 4; n++) begin
      send_item(item_t'{16'h0001 << n, 16'h8000, n == 3});
    end
  endtask

  // every key new: each item is a group of its own
  task automatic test_distinct_keys();
    for (int unsigned n = 0; n < 5; n++) begin
      send_item(item_t'{16'($urandom), 16'(n), n == 4});
    end
  endtask

  // full store and group table, then overflow, including a dropped last item
  task automatic test_store_full();
    send_list(StoreDepth, 1, 1'b1);
    send_list(StoreDepth + 2, 4, 1'b0);
    no_idle = 1'b1;
    send_list(StoreDepth + 8, 8, 1'b0);
    no_idle = 1'b0;
  endtask

  // mostly short lists, now and then a long one, with bursts of back-to-back transactions
  task automatic test_random_lists();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RandomItems) begin
      no_idle = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, StoreDepth + 6)
                                         : $urandom_range(1, 12);
      send_list(len, $urandom_range(1, 8), $urandom_range(0, 9) == 0);
      sent += len;
    end
    no_idle = 1'b0;
  endtask

  // result checker: every strobe is one transaction, matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o !== 1'b0) begin
      if (grouped_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", result_seen));
      end else begin
        want = grouped_q.pop_front();
        if (result_o.handle_out !== want.handle_out) begin
          report_mismatch($sformatf("result %0d handle_out got %h want %h",
                                    result_seen, result_o.handle_out, want.handle_out));
        end
        if (result_o.key_out !== want.key_out) begin
          report_mismatch($sformatf("result %0d key_out got %h want %h",
                                    result_seen, result_o.key_out, want.key_out));
        end
        if (result_o.last_out !== want.last_out) begin
          report_mismatch($sformatf("result %0d last_out got %b want %b",
                                    result_seen, result_o.last_out, want.last_out));
        end
        if (result_o.overflow !== want.overflow) begin
          report_mismatch($sformatf("result %0d overflow got %b want %b",
                                    result_seen, result_o.overflow, want.overflow));
        end
      end
      result_seen++;
    end
  end

  // watchdog on a hung handshake or a missing result
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("stable_group_by_key: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_item();
    test_field_extremes();
    test_interleaved_keys();
    test_one_group();
    test_distinct_keys();
    test_store_full();
    test_random_lists();
    start <= 1'b0;
    // drain the last list, then watch for stray results
    while (grouped_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("stable_group_by_key: match");
    end else begin
      $display("stable_group_by_key: mismatch");
    end
    $finish;
  end

endmodule
